// ----- design/midpoint_ellipse_rasterizer_core_defines.svh -----
// Assertion macros for the midpoint ellipse rasterizer.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent
`define MER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MER_ASSERT_NOW(label, ante, cons, msg)
`define MER_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- design/mer_pkg.sv -----
// Shared types and constants of the midpoint ellipse rasterizer.
// No dependencies; used by the interfaces, controller, datapath and top level.
package mer_pkg;

    // Output coordinate width (sums wrap to this width)
    localparam int OUT_BITS = 13;

    // Request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Shared multiplier operand selection and destination
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX_SQ_RY,
        MUL_T_T,
        MUL_U_U,
        MUL_RY_SQ_A,
        MUL_RX_SQ_B,
        MUL_RX_SQ_RY_SQ
    } mul_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load_start;
        mul_sel_t mul_op;
        logic     init_sum;
        logic     switch_sum;
        logic     emit_step;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic switch_needed;
        logic last;
        logic out_stall;
    } dp_status_t;

endpackage

// ----- design/mer_if.sv -----
// Request and result channel interfaces of the ellipse rasterizer.
// Depends on mer_pkg for the output coordinate width.
interface mer_cmd_if #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic        [RADIUS_BITS-1:0] radius_x;
    logic        [RADIUS_BITS-1:0] radius_y;
    logic signed [COORD_BITS-1:0]  centre_x;
    logic signed [COORD_BITS-1:0]  centre_y;

    modport source (output valid, output op, output radius_x, output radius_y,
                    output centre_x, output centre_y, input ready);
    modport sink   (input valid, input op, input radius_x, input radius_y,
                    input centre_x, input centre_y, output ready);
endinterface

interface mer_pt_if;
    logic                              valid;
    logic                              ready;
    logic signed [mer_pkg::OUT_BITS-1:0] right_x;
    logic signed [mer_pkg::OUT_BITS-1:0] left_x;
    logic signed [mer_pkg::OUT_BITS-1:0] upper_y;
    logic signed [mer_pkg::OUT_BITS-1:0] lower_y;
    logic                              last;

    modport source (output valid, output right_x, output left_x, output upper_y,
                    output lower_y, output last, input ready);
    modport sink   (input valid, input right_x, input left_x, input upper_y,
                    input lower_y, input last, output ready);
endinterface

// ----- design/mer_ctrl.sv -----
// Sequencing controller of the ellipse rasterizer.
// Depends on mer_pkg; drives datapath commands from request handshake and status.
module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_op,
    output logic                req_ready,
    input  mer_pkg::dp_status_t sts,
    output mer_pkg::dp_cmd_t    dcmd
);

    typedef enum logic [3:0] {
        S_WAIT,
        S_LD_RX,
        S_LD_RY,
        S_LD_P,
        S_LD_SUM,
        S_SW_T,
        S_SW_U,
        S_SW_A,
        S_SW_B,
        S_SW_C,
        S_SW_SUM,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   accept;

    // Ready only while waiting and the result slot is free
    assign req_ready = (state_reg == S_WAIT) && !sts.out_stall;
    assign accept    = req_valid && req_ready;

    // Next state and command decode
    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        dcmd.load_start = 1'b0;
        dcmd.mul_op     = mer_pkg::MUL_NONE;
        dcmd.init_sum   = 1'b0;
        dcmd.switch_sum = 1'b0;
        dcmd.emit_step  = 1'b0;
        case (state_reg)
            S_WAIT:
            begin
                if (accept)
                begin
                    if (req_op == mer_pkg::OP_START)
                    begin
                        dcmd.load_start = 1'b1;
                        busy_next       = 1'b1;
                        state_next      = S_LD_RX;
                    end
                    else if (busy_reg)
                    begin
                        if (sts.switch_needed)
                        begin
                            state_next = S_SW_T;
                        end
                        else
                        begin
                            dcmd.emit_step = 1'b1;
                            if (sts.last)
                            begin
                                busy_next = 1'b0;
                            end
                        end
                    end
                end
            end
            S_LD_RX:
            begin
                dcmd.mul_op = mer_pkg::MUL_RX_RX;
                state_next  = S_LD_RY;
            end
            S_LD_RY:
            begin
                dcmd.mul_op = mer_pkg::MUL_RY_RY;
                state_next  = S_LD_P;
            end
            S_LD_P:
            begin
                dcmd.mul_op = mer_pkg::MUL_RX_SQ_RY;
                state_next  = S_LD_SUM;
            end
            S_LD_SUM:
            begin
                dcmd.init_sum = 1'b1;
                state_next    = S_WAIT;
            end
            S_SW_T:
            begin
                dcmd.mul_op = mer_pkg::MUL_T_T;
                state_next  = S_SW_U;
            end
            S_SW_U:
            begin
                dcmd.mul_op = mer_pkg::MUL_U_U;
                state_next  = S_SW_A;
            end
            S_SW_A:
            begin
                dcmd.mul_op = mer_pkg::MUL_RY_SQ_A;
                state_next  = S_SW_B;
            end
            S_SW_B:
            begin
                dcmd.mul_op = mer_pkg::MUL_RX_SQ_B;
                state_next  = S_SW_C;
            end
            S_SW_C:
            begin
                dcmd.mul_op = mer_pkg::MUL_RX_SQ_RY_SQ;
                state_next  = S_SW_SUM;
            end
            S_SW_SUM:
            begin
                dcmd.switch_sum = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                dcmd.emit_step = 1'b1;
                if (sts.last)
                begin
                    busy_next = 1'b0;
                end
                state_next = S_WAIT;
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    // State and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WAIT;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ----- design/mer_datapath.sv -----
// Datapath of the ellipse rasterizer: shared multiplier, decision and slope
// registers, offsets and the result register. Depends on mer_pkg.
module mer_datapath #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mer_pkg::dp_cmd_t                     dcmd,
    output mer_pkg::dp_status_t                  sts,
    input  logic        [RADIUS_BITS-1:0]        radius_x,
    input  logic        [RADIUS_BITS-1:0]        radius_y,
    input  logic signed [COORD_BITS-1:0]         centre_x,
    input  logic signed [COORD_BITS-1:0]         centre_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mer_pkg::OUT_BITS-1:0]  right_x,
    output logic signed [mer_pkg::OUT_BITS-1:0]  left_x,
    output logic signed [mer_pkg::OUT_BITS-1:0]  upper_y,
    output logic signed [mer_pkg::OUT_BITS-1:0]  lower_y,
    output logic                                 last
);

    localparam int RW  = RADIUS_BITS;
    localparam int OW  = RW + 1;        // offsets
    localparam int SQW = 2 * RW;        // radius squares
    localparam int SW  = 3 * RW + 4;    // slopes
    localparam int MW  = 2 * RW + 4;    // multiplier operand
    localparam int DW  = 2 * MW;        // decision and products
    localparam int OB  = mer_pkg::OUT_BITS;

    logic        [RW-1:0]  rad_x_reg, rad_y_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic        [OW-1:0]  off_x_reg, off_y_reg;
    logic        [SQW-1:0] rx_sq_reg, ry_sq_reg;
    logic        [DW-1:0]  acc_a_reg, acc_b_reg, acc_c_reg;
    logic        [SW-1:0]  slope_x_reg, slope_y_reg;
    logic        [DW-1:0]  dec_reg;
    logic                  region2_reg;
    logic                  out_valid_reg;
    logic signed [OB-1:0]  right_x_reg, left_x_reg, upper_y_reg, lower_y_reg;
    logic                  last_reg;

    logic [RW-1:0] rx_in, ry_in;
    logic [MW-1:0] mul_a, mul_b;
    logic [DW-1:0] prod;
    logic [OW-1:0] u_val;
    logic          at_last;

    logic [SW-1:0] two_rx, two_ry, sx_inc, sy_dec;
    logic [SW-1:0] slope_x_step, slope_y_step;
    logic [OW-1:0] off_x_step, off_y_step;
    logic [DW-1:0] dec_term, dec_step;
    logic          dec_neg, dec_pos;

    // Zero radius raised to one
    assign rx_in = (radius_x == '0) ? RW'(1) : radius_x;
    assign ry_in = (radius_y == '0) ? RW'(1) : radius_y;

    // (y - 1) squared needs |y - 1|; y = 0 gives one
    assign u_val = (off_y_reg == '0) ? OW'(1) : (off_y_reg - OW'(1));

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (dcmd.mul_op)
            mer_pkg::MUL_RX_RX:
            begin
                mul_a = MW'(rad_x_reg);
                mul_b = MW'(rad_x_reg);
            end
            mer_pkg::MUL_RY_RY:
            begin
                mul_a = MW'(rad_y_reg);
                mul_b = MW'(rad_y_reg);
            end
            mer_pkg::MUL_RX_SQ_RY:
            begin
                mul_a = MW'(rx_sq_reg);
                mul_b = MW'(rad_y_reg);
            end
            mer_pkg::MUL_T_T:
            begin
                mul_a = MW'({off_x_reg, 1'b1});
                mul_b = MW'({off_x_reg, 1'b1});
            end
            mer_pkg::MUL_U_U:
            begin
                mul_a = MW'(u_val);
                mul_b = MW'(u_val);
            end
            mer_pkg::MUL_RY_SQ_A:
            begin
                mul_a = MW'(ry_sq_reg);
                mul_b = acc_a_reg[MW-1:0];
            end
            mer_pkg::MUL_RX_SQ_B:
            begin
                mul_a = MW'(rx_sq_reg);
                mul_b = acc_b_reg[MW-1:0];
            end
            mer_pkg::MUL_RX_SQ_RY_SQ:
            begin
                mul_a = MW'(rx_sq_reg);
                mul_b = MW'(ry_sq_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = DW'(mul_a) * DW'(mul_b);

    // One midpoint iteration; slopes move by 2*r^2 per unit offset change
    assign two_rx  = SW'({rx_sq_reg, 1'b0});
    assign two_ry  = SW'({ry_sq_reg, 1'b0});
    assign sx_inc  = slope_x_reg + two_ry;
    assign sy_dec  = slope_y_reg - two_rx;
    assign dec_neg = dec_reg[DW-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);

    always_comb
    begin
        off_x_step   = off_x_reg;
        off_y_step   = off_y_reg;
        slope_x_step = slope_x_reg;
        slope_y_step = slope_y_reg;
        if (!region2_reg)
        begin
            off_x_step   = off_x_reg + OW'(1);
            slope_x_step = sx_inc;
            if (dec_neg)
            begin
                dec_term = DW'(sx_inc) + DW'(ry_sq_reg);
            end
            else
            begin
                off_y_step   = off_y_reg - OW'(1);
                slope_y_step = sy_dec;
                dec_term     = DW'(sx_inc) - DW'(sy_dec) + DW'(ry_sq_reg);
            end
        end
        else if (dec_pos)
        begin
            off_y_step   = off_y_reg - OW'(1);
            slope_y_step = sy_dec;
            dec_term     = DW'(rx_sq_reg) - DW'(sy_dec);
        end
        else
        begin
            off_x_step   = off_x_reg + OW'(1);
            off_y_step   = off_y_reg - OW'(1);
            slope_x_step = sx_inc;
            slope_y_step = sy_dec;
            dec_term     = DW'(sx_inc) - DW'(sy_dec) + DW'(rx_sq_reg);
        end
        dec_step = dec_reg + {dec_term[DW-3:0], 2'b00};
    end

    assign at_last = region2_reg && (off_y_reg == '0);

    // Status to the controller
    assign sts.switch_needed = !region2_reg && !(slope_x_reg < slope_y_reg);
    assign sts.last          = at_last;
    assign sts.out_stall     = out_valid_reg && !out_ready;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region2_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dcmd.load_start || dcmd.init_sum)
            begin
                region2_reg <= 1'b0;
            end
            else if (dcmd.switch_sum)
            begin
                region2_reg <= 1'b1;
            end
            if (dcmd.emit_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (dcmd.load_start)
        begin
            rad_x_reg   <= rx_in;
            rad_y_reg   <= ry_in;
            cx_reg      <= centre_x;
            cy_reg      <= centre_y;
            off_x_reg   <= '0;
            off_y_reg   <= OW'(ry_in);
            slope_x_reg <= '0;
        end

        // Product write back
        case (dcmd.mul_op)
            mer_pkg::MUL_RX_RX:       rx_sq_reg <= prod[SQW-1:0];
            mer_pkg::MUL_RY_RY:       ry_sq_reg <= prod[SQW-1:0];
            mer_pkg::MUL_RX_SQ_RY,
            mer_pkg::MUL_T_T,
            mer_pkg::MUL_RY_SQ_A:     acc_a_reg <= prod;
            mer_pkg::MUL_U_U,
            mer_pkg::MUL_RX_SQ_B:     acc_b_reg <= prod;
            mer_pkg::MUL_RX_SQ_RY_SQ: acc_c_reg <= prod;
            default:
            begin
            end
        endcase

        // Region one start: 4ry^2 - 4rx^2*ry + rx^2
        if (dcmd.init_sum)
        begin
            slope_y_reg <= {acc_a_reg[SW-2:0], 1'b0};
            dec_reg     <= DW'({ry_sq_reg, 2'b00}) - {acc_a_reg[DW-3:0], 2'b00}
                           + DW'(rx_sq_reg);
        end

        // Region two start: ry^2(2x+1)^2 + 4rx^2(y-1)^2 - 4rx^2ry^2
        if (dcmd.switch_sum)
        begin
            dec_reg <= acc_a_reg + {acc_b_reg[DW-3:0], 2'b00}
                       - {acc_c_reg[DW-3:0], 2'b00};
        end

        // Emit the current points, then advance unless this is the last one
        if (dcmd.emit_step)
        begin
            right_x_reg <= OB'(cx_reg) + OB'(off_x_reg);
            left_x_reg  <= OB'(cx_reg) - OB'(off_x_reg);
            upper_y_reg <= OB'(cy_reg) + OB'(off_y_reg);
            lower_y_reg <= OB'(cy_reg) - OB'(off_y_reg);
            last_reg    <= at_last;
            if (!at_last)
            begin
                off_x_reg   <= off_x_step;
                off_y_reg   <= off_y_step;
                slope_x_reg <= slope_x_step;
                slope_y_reg <= slope_y_step;
                dec_reg     <= dec_step;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign right_x   = right_x_reg;
    assign left_x    = left_x_reg;
    assign upper_y   = upper_y_reg;
    assign lower_y   = lower_y_reg;
    assign last      = last_reg;

endmodule

// ----- design/midpoint_ellipse_rasterizer_core.sv -----
// Channel  Dir  Payload                                   Handshake
// cmd      in   op, radius_x, radius_y, centre_x, centre_y valid/ready
// pts      out  right_x, left_x, upper_y, lower_y, last    valid/ready
//
// A step in either region emits as soon as it is accepted; the step that crosses
// into region two first runs five products on the one shared multiplier and
// one sum, then emits. A start runs three products and one sum. A step while
// idle emits nothing. Reset leaves the block idle with no ellipse loaded.
// cmd.ready drops while a result is held and pts.ready is low.
//
// Top level of the midpoint ellipse rasterizer; depends on mer_pkg, mer_if,
// mer_ctrl, mer_datapath and the assertion macro header.
`include "midpoint_ellipse_rasterizer_core_defines.svh"

module midpoint_ellipse_rasterizer_core #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    mer_cmd_if.sink       cmd,
    mer_pt_if.source      pts
);

    mer_pkg::dp_cmd_t    dcmd;
    mer_pkg::dp_status_t sts;

    // Sequencing controller
    mer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (cmd.valid),
        .req_op    (cmd.op),
        .req_ready (cmd.ready),
        .sts       (sts),
        .dcmd      (dcmd)
    );

    // Arithmetic and result register
    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dcmd      (dcmd),
        .sts       (sts),
        .radius_x  (cmd.radius_x),
        .radius_y  (cmd.radius_y),
        .centre_x  (cmd.centre_x),
        .centre_y  (cmd.centre_y),
        .out_valid (pts.valid),
        .out_ready (pts.ready),
        .right_x   (pts.right_x),
        .left_x    (pts.left_x),
        .upper_y   (pts.upper_y),
        .lower_y   (pts.lower_y),
        .last      (pts.last)
    );

    // A step is never emitted from region one past the switch point
    `MER_ASSERT_NOW(a_emit_no_switch, dcmd.emit_step, !sts.switch_needed, "emit before region switch")
    // The region two start sum leaves nothing left to switch
    `MER_ASSERT_NEXT(a_switch_done, dcmd.switch_sum, !sts.switch_needed, "region switch not taken")
    // An emit never overwrites a result still waiting
    `MER_ASSERT_NOW(a_emit_slot_free, dcmd.emit_step, !sts.out_stall, "result overwritten")
    // A fresh ellipse starts in region one
    `MER_ASSERT_NEXT(a_init_region_one, dcmd.init_sum, !sts.switch_needed, "bad region one start")

endmodule
